[design/spk_pkg.sv]
package spk_pkg;

  localparam int WORD_W      = 32;
  localparam int BLK_W       = 2 * WORD_W;
  localparam int ROUND_COUNT = 27;
  localparam int ROT_A       = 8;
  localparam int ROT_B       = 3;
  localparam int CFG_IDX_W   = 3;

  // Register reset values
  localparam logic [WORD_W-1:0] KEY_RST     = 32'h0000_0000;
  localparam logic [WORD_W-1:0] IV_LOW_RST  = 32'h0123_4567;
  localparam logic [WORD_W-1:0] IV_HIGH_RST = 32'h89AB_CDEF;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_DIR     = 3'd4,
    REG_IV_LOW  = 3'd5,
    REG_IV_HIGH = 3'd6
  } cfg_reg_e;

  // Direction codes
  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] block_high;
    logic [WORD_W-1:0] block_low;
  } spk_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_high;
    logic [WORD_W-1:0] result_low;
  } spk_out_t;

  // Round core status towards the top level
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int unsigned r);
    return (v >> r) | (v << (WORD_W - r));
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

endpackage

[design/spk_key_sched.sv]
module spk_key_sched #(
  parameter int ROUNDS = spk_pkg::ROUND_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [spk_pkg::WORD_W-1:0]            key_in [4],
  input  logic [$clog2(ROUNDS)-1:0]             rd_idx,
  output logic [spk_pkg::WORD_W-1:0]            rk_o,
  output logic                                  busy_o
);
  import spk_pkg::*;

  localparam int RIDX_W = $clog2(ROUNDS);

  logic [WORD_W-1:0] rk_mem [ROUNDS];
  logic [WORD_W-1:0] k_r, k_nxt;
  logic [WORD_W-1:0] l_r [3];
  logic [WORD_W-1:0] nl;
  logic [RIDX_W-1:0] i_r;
  logic              busy_r;
  logic              last;

  // One schedule step per cycle; the l words rotate so l_r[0] always holds l[i]
  assign nl     = (rotr(l_r[0], ROT_A) + k_r) ^ WORD_W'(i_r);
  assign k_nxt  = rotl(k_r, ROT_B) ^ nl;
  assign last   = (i_r == RIDX_W'(ROUNDS - 1));
  assign busy_o = busy_r;
  assign rk_o   = rk_mem[rd_idx];

  // Sequencer; reset expands the reset key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      i_r    <= '0;
      k_r    <= KEY_RST;
      l_r[0] <= KEY_RST;
      l_r[1] <= KEY_RST;
      l_r[2] <= KEY_RST;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r    <= '0;
      k_r    <= key_in[0];
      l_r[0] <= key_in[1];
      l_r[1] <= key_in[2];
      l_r[2] <= key_in[3];
    end else if (busy_r) begin
      k_r    <= k_nxt;
      l_r[0] <= l_r[1];
      l_r[1] <= l_r[2];
      l_r[2] <= nl;
      i_r    <= i_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Round key store
  always_ff @(posedge clk) begin
    if (busy_r && !start) begin
      rk_mem[i_r] <= k_r;
    end
  end

endmodule

[design/spk_round_core.sv]
module spk_round_core #(
  parameter int ROUNDS = spk_pkg::ROUND_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  dir_in,
  input  logic [spk_pkg::WORD_W-1:0]            x_in,
  input  logic [spk_pkg::WORD_W-1:0]            y_in,
  input  logic                                  release_in,
  input  logic [spk_pkg::WORD_W-1:0]            rk_in,
  output logic [$clog2(ROUNDS)-1:0]             rk_idx,
  output logic [spk_pkg::WORD_W-1:0]            x_o,
  output logic [spk_pkg::WORD_W-1:0]            y_o,
  output spk_pkg::core_stat_t                   stat_o
);
  import spk_pkg::*;

  localparam int RIDX_W = $clog2(ROUNDS);

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_DONE
  } core_state_t;

  core_state_t       state_r;
  logic [RIDX_W-1:0] cnt_r;
  logic              dir_r;
  logic [WORD_W-1:0] x_r, y_r;
  logic [WORD_W-1:0] x_nxt, y_nxt;
  logic [WORD_W-1:0] dy;

  // Decrypt walks the key store backwards
  assign rk_idx = (dir_r == DIR_DEC) ? RIDX_W'(ROUNDS - 1) - cnt_r : cnt_r;

  // Shared round unit: one forward or inverse round per cycle
  assign dy = rotr(y_r ^ x_r, ROT_B);
  always_comb begin
    if (dir_r == DIR_DEC) begin
      y_nxt = dy;
      x_nxt = rotl((x_r ^ rk_in) - dy, ROT_A);
    end else begin
      x_nxt = (rotr(x_r, ROT_A) + y_r) ^ rk_in;
      y_nxt = rotl(y_r, ROT_B) ^ x_nxt;
    end
  end

  assign x_o         = x_r;
  assign y_o         = y_r;
  assign stat_o.busy = (state_r == C_RUN);
  assign stat_o.done = (state_r == C_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      cnt_r   <= '0;
      dir_r   <= DIR_ENC;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (start) begin
            state_r <= C_RUN;
            cnt_r   <= '0;
            dir_r   <= dir_in;
            x_r     <= x_in;
            y_r     <= y_in;
          end
        end
        C_RUN: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == RIDX_W'(ROUNDS - 1)) begin
            state_r <= C_DONE;
          end
        end
        C_DONE: begin
          if (release_in) begin
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule

[design/speck64_128_cbc_cipher_top.sv]
// Speck64/128 block cipher in CBC mode, one 64-bit block per request.
//
// Input channel in_valid/in_stall/in_data carries a block; the result leaves
// on out_valid/out_stall/out_data. A request moves when valid is high and
// stall is low. Configuration writes use cfg_valid/cfg_ready with cfg_index
// (0-3 key words, 4 direction, 5-6 initial vector) and cfg_data. Any write
// re-expands the round keys (in_stall high meanwhile) and
// reloads the chain from the initial vector; unknown indexes are ignored.
// A pending configuration write takes priority: in_stall is high while
// cfg_valid is high.
//
// Datapath order: the block is loaded into the round core at the accepting
// edge, passes through every round of the single shared round unit, then
// moves to the output register. One block is processed at a time: a new
// block is accepted only after the previous one has left the round core.
// Reset expands the reset key (input stalled) and sets the chain
// to the reset initial vector. A stalled result holds in the output register
// while the next block is accepted; that block finishes and waits until the
// output register frees.
module speck64_128_cbc_cipher_top #(
  parameter int ROUNDS = spk_pkg::ROUND_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  spk_pkg::spk_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output spk_pkg::spk_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]        cfg_data
);
  import spk_pkg::*;

  localparam int RIDX_W = $clog2(ROUNDS);

  logic [WORD_W-1:0] key_r [4];
  logic [WORD_W-1:0] key_nxt [4];
  logic              dir_r, dir_nxt;
  logic [WORD_W-1:0] iv_low_r, iv_low_nxt;
  logic [WORD_W-1:0] iv_high_r, iv_high_nxt;
  logic              cfg_hit;
  logic              cfg_wr;
  logic [BLK_W-1:0]  chain_r;
  logic [BLK_W-1:0]  ct_r;
  logic              out_valid_r;
  spk_out_t          out_data_r;
  logic              in_acc;
  logic              out_load;
  logic              ks_busy;
  logic [WORD_W-1:0] rk;
  logic [RIDX_W-1:0] rk_idx;
  logic [WORD_W-1:0] core_x, core_y;
  logic [WORD_W-1:0] x_start, y_start;
  core_stat_t        core_stat;
  spk_out_t          res;

  // Handshakes
  assign cfg_ready = !(core_stat.busy || core_stat.done);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = ks_busy || core_stat.busy || core_stat.done || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = core_stat.done && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Register write decode
  always_comb begin
    key_nxt     = key_r;
    dir_nxt     = dir_r;
    iv_low_nxt  = iv_low_r;
    iv_high_nxt = iv_high_r;
    cfg_hit     = 1'b1;
    case (cfg_reg_e'(cfg_index))
      REG_KEY0:    key_nxt[0]  = cfg_data;
      REG_KEY1:    key_nxt[1]  = cfg_data;
      REG_KEY2:    key_nxt[2]  = cfg_data;
      REG_KEY3:    key_nxt[3]  = cfg_data;
      REG_DIR:     dir_nxt     = cfg_data[0];
      REG_IV_LOW:  iv_low_nxt  = cfg_data;
      REG_IV_HIGH: iv_high_nxt = cfg_data;
      default:     cfg_hit     = 1'b0;
    endcase
  end

  // Chain XOR into the first round input for encryption
  assign x_start = (dir_r == DIR_ENC) ? in_data.block_low ^ chain_r[WORD_W-1:0]
                                      : in_data.block_low;
  assign y_start = (dir_r == DIR_ENC) ? in_data.block_high ^ chain_r[BLK_W-1:WORD_W]
                                      : in_data.block_high;

  // Final chain XOR for decryption
  always_comb begin
    if (dir_r == DIR_DEC) begin
      res.result_low  = core_x ^ chain_r[WORD_W-1:0];
      res.result_high = core_y ^ chain_r[BLK_W-1:WORD_W];
    end else begin
      res.result_low  = core_x;
      res.result_high = core_y;
    end
  end

  // Configuration, chain and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]    <= KEY_RST;
      key_r[1]    <= KEY_RST;
      key_r[2]    <= KEY_RST;
      key_r[3]    <= KEY_RST;
      dir_r       <= DIR_ENC;
      iv_low_r    <= IV_LOW_RST;
      iv_high_r   <= IV_HIGH_RST;
      chain_r     <= {IV_HIGH_RST, IV_LOW_RST};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_hit) begin
        key_r     <= key_nxt;
        dir_r     <= dir_nxt;
        iv_low_r  <= iv_low_nxt;
        iv_high_r <= iv_high_nxt;
        chain_r   <= {iv_high_nxt, iv_low_nxt};
      end else if (out_load) begin
        chain_r <= (dir_r == DIR_DEC) ? ct_r : {core_y, core_x};
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ct_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  spk_key_sched #(
    .ROUNDS (ROUNDS)
  ) u_ks (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_wr && cfg_hit),
    .key_in (key_nxt),
    .rd_idx (rk_idx),
    .rk_o   (rk),
    .busy_o (ks_busy)
  );

  spk_round_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .dir_in     (dir_r),
    .x_in       (x_start),
    .y_in       (y_start),
    .release_in (out_load),
    .rk_in      (rk),
    .rk_idx     (rk_idx),
    .x_o        (core_x),
    .y_o        (core_y),
    .stat_o     (core_stat)
  );

endmodule
